FILE: src/ssd_pkg.sv
// types, widths and codes shared by the sample standard deviation block
// no dependencies; imported by ssd_alu and sample_std_dev_top
package ssd_pkg;

    localparam int MAX_SAMPLES = 65536;
    localparam int SAMPLE_BITS = 16;

    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int SQR_W  = 2 * SAMPLE_BITS;
    localparam int SUM_W  = SAMPLE_BITS + CNT_W;
    localparam int SQ_W   = 2 * SAMPLE_BITS - 2 + CNT_W;
    localparam int P_W    = (CNT_W + SQ_W > 2 * SUM_W) ? CNT_W + SQ_W : 2 * SUM_W;
    localparam int FRAC_W = 16;
    localparam int D_W    = P_W + FRAC_W;
    localparam int DV_W   = 2 * CNT_W;
    localparam int RT_IN_W = 64;
    localparam int RT_ITERS = RT_IN_W / 2;
    localparam int OUT_W  = 24;
    localparam int A_W    = (P_W > RT_IN_W) ? P_W : RT_IN_W;
    localparam int STEP_W = $clog2(D_W + 1);

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TOO_FEW  = 2'd1;
    localparam logic [1:0] ST_TOO_MANY = 2'd2;

    typedef struct packed {
        logic           sub;
        logic [A_W-1:0] a;
        logic [A_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [A_W-1:0] sum;
        logic           carry;
    } alu_rsp_t;

endpackage

FILE: src/sample_std_dev_top.sv
// top level of the sample standard deviation block
// depends on ssd_pkg and ssd_alu
//
// usage
// - input channel: sample and last, taken when in_valid is high and in_stall low
// - samples that are not last are taken one per cycle while in_stall is low
//   and only update the count, the sum, the sum of squares and the overflow flag
// - the last sample of a set starts the end-of-set sequence: two shift-add
//   multiplies of SUM_W steps each, one subtract, a restoring divide of D_W
//   steps and a square root of RT_ITERS steps, all on one shared adder
// - in_stall is high for the whole sequence; a one-sample set skips the
//   arithmetic and goes straight to the output register
// - the result (std_dev_q8, status, sample_count) sits in an output register
//   with out_valid; a stalled result holds, and the next set is accumulated
//   meanwhile, only a finished sequence waits for the output to free up
// - reset clears the accumulators, the sequencer and out_valid
module sample_std_dev_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic signed [ssd_pkg::SAMPLE_BITS-1:0] sample,
    input  logic                            last,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [ssd_pkg::OUT_W-1:0]       std_dev_q8,
    output logic [1:0]                      status,
    output logic [ssd_pkg::CNT_W-1:0]       sample_count
);
    import ssd_pkg::*;

    // sequencer phases
    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_MUL1 = 3'd1;
    localparam logic [2:0] PH_MUL2 = 3'd2;
    localparam logic [2:0] PH_SUB  = 3'd3;
    localparam logic [2:0] PH_DIV  = 3'd4;
    localparam logic [2:0] PH_SQRT = 3'd5;
    localparam logic [2:0] PH_DONE = 3'd6;

    localparam logic [RT_IN_W-1:0] RT_BIT0 = RT_IN_W'(1) << (RT_IN_W - 2);
    localparam logic [RT_IN_W-1:0] OUT_MAX = RT_IN_W'({OUT_W{1'b1}});

    // running accumulators
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [SQ_W-1:0]         sq_reg, sq_next;
    logic                    ovf_reg, ovf_next;

    // sequencer and working registers
    logic [2:0]              phase_reg, phase_next;
    logic [STEP_W-1:0]       step_reg, step_next;
    logic [CNT_W-1:0]        n_reg, n_next;
    logic [SQ_W-1:0]         s2_reg, s2_next;
    logic [SUM_W-1:0]        mag_reg, mag_next;
    logic [SUM_W-1:0]        mplr_reg, mplr_next;
    logic [P_W-1:0]          acc_reg, acc_next;
    logic [P_W-1:0]          prod_reg, prod_next;
    logic [D_W-1:0]          num_reg, num_next;
    logic [DV_W-1:0]         rem_reg, rem_next;
    logic [DV_W-1:0]         dvs_reg, dvs_next;
    logic [RT_IN_W-1:0]      x_reg, x_next;
    logic [RT_IN_W-1:0]      res_reg, res_next;
    logic [RT_IN_W-1:0]      bit_reg, bit_next;
    logic [1:0]              stat_reg, stat_next;

    // output register
    logic                    out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]        std_reg, std_next;
    logic [1:0]              ostat_reg, ostat_next;
    logic [CNT_W-1:0]        ocnt_reg, ocnt_next;

    logic                    in_take;
    logic                    out_free;
    logic signed [SUM_W-1:0] sx;
    logic signed [SQR_W-1:0] sq_s;
    logic [CNT_W-1:0]        cnt_acc;
    logic signed [SUM_W-1:0] sum_acc;
    logic [SQ_W-1:0]         sq_acc;
    logic                    ovf_acc;
    logic [CNT_W-1:0]        n_m1;
    logic [D_W-1:0]          div_shift;
    logic [RT_IN_W-1:0]      root_next;

    alu_req_t alu_req;
    alu_rsp_t alu_rsp;

    ssd_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    assign in_stall = (phase_reg != PH_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // per-sample update, the count saturates and later samples are dropped
    assign sx   = SUM_W'(sample);
    assign sq_s = SQR_W'(sample) * SQR_W'(sample);

    always_comb
    begin
        if (cnt_reg < CNT_W'(MAX_SAMPLES))
        begin
            cnt_acc = cnt_reg + CNT_W'(1);
            sum_acc = sum_reg + sx;
            sq_acc  = sq_reg + SQ_W'($unsigned(sq_s));
            ovf_acc = ovf_reg;
        end
        else
        begin
            cnt_acc = cnt_reg;
            sum_acc = sum_reg;
            sq_acc  = sq_reg;
            ovf_acc = 1'b1;
        end
    end

    assign n_m1 = n_reg - CNT_W'(1);

    // shared adder operands by phase
    always_comb
    begin
        alu_req.sub = 1'b1;
        alu_req.a   = '0;
        alu_req.b   = '0;
        case (phase_reg)
            PH_MUL1:
            begin
                alu_req.sub = 1'b0;
                alu_req.a   = A_W'({acc_reg[P_W-2:0], 1'b0});
                alu_req.b   = mplr_reg[SUM_W-1] ? A_W'(s2_reg) : '0;
            end
            PH_MUL2:
            begin
                alu_req.sub = 1'b0;
                alu_req.a   = A_W'({acc_reg[P_W-2:0], 1'b0});
                alu_req.b   = mplr_reg[SUM_W-1] ? A_W'(mag_reg) : '0;
            end
            PH_SUB:
            begin
                alu_req.a = A_W'(prod_reg);
                alu_req.b = A_W'(acc_reg);
            end
            PH_DIV:
            begin
                alu_req.a = A_W'({rem_reg, num_reg[D_W-1]});
                alu_req.b = A_W'(dvs_reg);
            end
            PH_SQRT:
            begin
                alu_req.a = A_W'(x_reg);
                alu_req.b = A_W'(res_reg | bit_reg);
            end
            default:
            begin
                alu_req.sub = 1'b1;
            end
        endcase
    end

    // quotient after this divide step, used for the handover to the root
    assign div_shift = {num_reg[D_W-2:0], alu_rsp.carry};
    // root after this step
    assign root_next = alu_rsp.carry ? ((res_reg >> 1) | bit_reg) : (res_reg >> 1);

    always_comb
    begin
        cnt_next       = cnt_reg;
        sum_next       = sum_reg;
        sq_next        = sq_reg;
        ovf_next       = ovf_reg;
        phase_next     = phase_reg;
        step_next      = step_reg;
        n_next         = n_reg;
        s2_next        = s2_reg;
        mag_next       = mag_reg;
        mplr_next      = mplr_reg;
        acc_next       = acc_reg;
        prod_next      = prod_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        dvs_next       = dvs_reg;
        x_next         = x_reg;
        res_next       = res_reg;
        bit_next       = bit_reg;
        stat_next      = stat_reg;
        out_valid_next = out_valid_reg && out_stall;
        std_next       = std_reg;
        ostat_next     = ostat_reg;
        ocnt_next      = ocnt_reg;

        case (phase_reg)
            PH_IDLE:
            begin
                if (in_take)
                begin
                    if (last)
                    begin
                        // snapshot the finished set and clear for the next one
                        cnt_next  = '0;
                        sum_next  = '0;
                        sq_next   = '0;
                        ovf_next  = 1'b0;
                        n_next    = cnt_acc;
                        s2_next   = sq_acc;
                        mag_next  = sum_acc[SUM_W-1] ? SUM_W'(-sum_acc) : SUM_W'(sum_acc);
                        acc_next  = '0;
                        mplr_next = SUM_W'(cnt_acc);
                        step_next = STEP_W'(SUM_W - 1);
                        if (cnt_acc < CNT_W'(2))
                        begin
                            res_next   = '0;
                            stat_next  = ST_TOO_FEW;
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            stat_next  = ovf_acc ? ST_TOO_MANY : ST_OK;
                            phase_next = PH_MUL1;
                        end
                    end
                    else
                    begin
                        cnt_next = cnt_acc;
                        sum_next = sum_acc;
                        sq_next  = sq_acc;
                        ovf_next = ovf_acc;
                    end
                end
            end
            PH_MUL1:
            begin
                // n * sum of squares, msb first
                acc_next  = alu_rsp.sum[P_W-1:0];
                mplr_next = {mplr_reg[SUM_W-2:0], 1'b0};
                step_next = step_reg - STEP_W'(1);
                if (step_reg == '0)
                begin
                    prod_next  = alu_rsp.sum[P_W-1:0];
                    acc_next   = '0;
                    mplr_next  = mag_reg;
                    step_next  = STEP_W'(SUM_W - 1);
                    phase_next = PH_MUL2;
                end
            end
            PH_MUL2:
            begin
                // square of the sum magnitude
                acc_next  = alu_rsp.sum[P_W-1:0];
                mplr_next = {mplr_reg[SUM_W-2:0], 1'b0};
                step_next = step_reg - STEP_W'(1);
                if (step_reg == '0)
                begin
                    phase_next = PH_SUB;
                end
            end
            PH_SUB:
            begin
                // difference clamped at zero, scaled by the fraction bits
                num_next   = alu_rsp.carry ? {alu_rsp.sum[P_W-1:0], {FRAC_W{1'b0}}} : '0;
                dvs_next   = DV_W'(n_reg) * DV_W'(n_m1);
                rem_next   = '0;
                step_next  = STEP_W'(D_W - 1);
                phase_next = PH_DIV;
            end
            PH_DIV:
            begin
                // restoring divide, quotient bits shift in at the bottom
                num_next  = div_shift;
                rem_next  = alu_rsp.carry ? alu_rsp.sum[DV_W-1:0]
                                          : alu_req.a[DV_W-1:0];
                step_next = step_reg - STEP_W'(1);
                if (step_reg == '0)
                begin
                    // quotient saturated to the root input width
                    x_next     = (|div_shift[D_W-1:RT_IN_W]) ? '1 : div_shift[RT_IN_W-1:0];
                    res_next   = '0;
                    bit_next   = RT_BIT0;
                    step_next  = STEP_W'(RT_ITERS - 1);
                    phase_next = PH_SQRT;
                end
            end
            PH_SQRT:
            begin
                if (alu_rsp.carry)
                begin
                    x_next = alu_rsp.sum[RT_IN_W-1:0];
                end
                res_next  = root_next;
                bit_next  = bit_reg >> 2;
                step_next = step_reg - STEP_W'(1);
                if (step_reg == '0)
                begin
                    phase_next = PH_DONE;
                end
            end
            PH_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    std_next       = (res_reg > OUT_MAX) ? {OUT_W{1'b1}} : res_reg[OUT_W-1:0];
                    ostat_next     = stat_reg;
                    ocnt_next      = n_reg;
                    phase_next     = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            sum_reg       <= '0;
            sq_reg        <= '0;
            ovf_reg       <= 1'b0;
            phase_reg     <= PH_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            sum_reg       <= sum_next;
            sq_reg        <= sq_next;
            ovf_reg       <= ovf_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        step_reg  <= step_next;
        n_reg     <= n_next;
        s2_reg    <= s2_next;
        mag_reg   <= mag_next;
        mplr_reg  <= mplr_next;
        acc_reg   <= acc_next;
        prod_reg  <= prod_next;
        num_reg   <= num_next;
        rem_reg   <= rem_next;
        dvs_reg   <= dvs_next;
        x_reg     <= x_next;
        res_reg   <= res_next;
        bit_reg   <= bit_next;
        stat_reg  <= stat_next;
        std_reg   <= std_next;
        ostat_reg <= ostat_next;
        ocnt_reg  <= ocnt_next;
    end

    assign out_valid    = out_valid_reg;
    assign std_dev_q8   = std_reg;
    assign status       = ostat_reg;
    assign sample_count = ocnt_reg;

endmodule

FILE: src/ssd_alu.sv
// shared add / subtract unit used by every step of the sequencer
// depends on ssd_pkg
module ssd_alu (
    input  ssd_pkg::alu_req_t req,
    output ssd_pkg::alu_rsp_t rsp
);
    import ssd_pkg::*;

    logic [A_W-1:0] b_op;
    logic [A_W:0]   full;

    // subtract as a + ~b + 1; carry out high means no borrow
    assign b_op = req.sub ? ~req.b : req.b;
    assign full = {1'b0, req.a} + {1'b0, b_op} + {{A_W{1'b0}}, req.sub};
    assign rsp.sum   = full[A_W-1:0];
    assign rsp.carry = full[A_W];

endmodule
